// File: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue core.
// Used by the channel interfaces, the storage cell and the top level.
// No dependencies.
package deq_pkg;

    // Default configuration
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_DATA_W     = 64;

    // Channel field widths
    localparam int FUNC_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK   = 4'd0,
        FN_PUSH_FRONT  = 4'd1,
        FN_POP_BACK    = 4'd2,
        FN_POP_FRONT   = 4'd3,
        FN_READ_BACK   = 4'd4,
        FN_READ_FRONT  = 4'd5,
        FN_WRITE_BACK  = 4'd6,
        FN_WRITE_FRONT = 4'd7,
        FN_CLEAR       = 4'd8
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cell command
    typedef enum logic [2:0] {
        CO_HOLD        = 3'd0,
        CO_FROM_LEFT   = 3'd1,
        CO_FROM_RIGHT  = 3'd2,
        CO_APPEND      = 3'd3,
        CO_DROP_TAIL   = 3'd4,
        CO_WRITE_TAIL  = 3'd5,
        CO_WRITE_HEAD  = 3'd6,
        CO_CLEAR       = 3'd7
    } cell_op_t;

endpackage

// File: sv/deq_req_if.sv
// Request channel: valid/ready handshake carrying func and value.
// Depends on deq_pkg for field widths.
interface deq_req_if;
    logic                        valid;
    logic                        ready;
    logic [deq_pkg::FUNC_W-1:0]  func;
    logic [deq_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

// File: sv/deq_rsp_if.sv
// Response channel: valid/ready handshake carrying data, count and status.
// Depends on deq_pkg for field widths.
interface deq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::RDATA_W-1:0]  data;
    logic [deq_pkg::COUNT_W-1:0]  count;
    logic [deq_pkg::STATUS_W-1:0] status;

    modport source (output valid, output data, output count, output status, input ready);
    modport sink   (input valid, input data, input count, input status, output ready);
endinterface

// File: sv/double_ended_queue_core.sv
// Double-ended queue core: a row of DEPTH cells, front entry in cell 0.
// The result of a request is registered and appears in the cycle after its transfer.
// Throughput: one request per cycle while results are taken; every request
// finishes in the cell row update. Reset clears all valid bits, the count
// and the result valid flag; the entry data is undefined until written.
// Depends on deq_pkg, deq_cell, deq_req_if and deq_rsp_if.
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);

    localparam int CntW    = $clog2(DEPTH + 1);
    localparam int CountW  = deq_pkg::COUNT_W;
    localparam int ExtW    = deq_pkg::MAX_DATA_W;
    localparam int RdataW  = deq_pkg::RDATA_W;
    localparam int ValueW  = deq_pkg::VALUE_W;

    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_data      [DEPTH];
    logic [DATA_WIDTH-1:0] cell_tail_data [DEPTH];
    deq_pkg::cell_op_t     row_op;
    deq_pkg::func_t        func;
    logic                  accept;
    logic                  empty;
    logic                  full;
    logic [DATA_WIDTH-1:0] value_w;
    logic [DATA_WIDTH-1:0] back_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [ExtW-1:0]       value_ext;
    logic [ExtW-1:0]       rd_ext;

    logic [CntW-1:0]       count_reg;
    logic [CntW-1:0]       count_next;
    logic                  rsp_valid_reg;
    logic [RdataW-1:0]     rsp_data_reg;
    logic [CountW-1:0]     rsp_count_reg;
    deq_pkg::status_t      rsp_status_reg;
    deq_pkg::status_t      status_next;

    // Handshake: take a request whenever the output register is free or drains
    assign req.ready = ~rsp_valid_reg | rsp.ready;
    assign accept    = req.valid & req.ready;

    assign func      = deq_pkg::func_t'(req.func);
    assign empty     = ~cell_valid[0];
    assign full      = cell_valid[DEPTH-1];
    assign value_ext = {{(ExtW - ValueW){1'b0}}, req.value};
    assign value_w   = value_ext[DATA_WIDTH-1:0];

    // Gather the back entry from the single tail cell
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tail_data[i];
        end
    end

    // Decode the request into a row command, the new count and the result
    always_comb
    begin
        row_op      = deq_pkg::CO_HOLD;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        rd_data     = '0;
        case (func)
            deq_pkg::FN_PUSH_BACK, deq_pkg::FN_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::ST_FULL;
                end
                else
                begin
                    row_op     = (func == deq_pkg::FN_PUSH_BACK) ?
                                 deq_pkg::CO_APPEND : deq_pkg::CO_FROM_LEFT;
                    count_next = count_reg + CntW'(1);
                end
            end
            deq_pkg::FN_POP_BACK, deq_pkg::FN_POP_FRONT,
            deq_pkg::FN_READ_BACK, deq_pkg::FN_READ_FRONT,
            deq_pkg::FN_WRITE_BACK, deq_pkg::FN_WRITE_FRONT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    case (func)
                        deq_pkg::FN_POP_BACK:
                        begin
                            row_op     = deq_pkg::CO_DROP_TAIL;
                            rd_data    = back_data;
                            count_next = count_reg - CntW'(1);
                        end
                        deq_pkg::FN_POP_FRONT:
                        begin
                            row_op     = deq_pkg::CO_FROM_RIGHT;
                            rd_data    = cell_data[0];
                            count_next = count_reg - CntW'(1);
                        end
                        deq_pkg::FN_READ_BACK:
                        begin
                            rd_data = back_data;
                        end
                        deq_pkg::FN_READ_FRONT:
                        begin
                            rd_data = cell_data[0];
                        end
                        deq_pkg::FN_WRITE_BACK:
                        begin
                            row_op = deq_pkg::CO_WRITE_TAIL;
                        end
                        deq_pkg::FN_WRITE_FRONT:
                        begin
                            row_op = deq_pkg::CO_WRITE_HEAD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            deq_pkg::FN_CLEAR:
            begin
                row_op     = deq_pkg::CO_CLEAR;
                count_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_ext = {{(ExtW - DATA_WIDTH){1'b0}}, rd_data};

    // Row of cells; cell 0 sees the incoming value as its left neighbour
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic                  l_valid;
        logic [DATA_WIDTH-1:0] l_data;
        logic                  r_valid;
        logic [DATA_WIDTH-1:0] r_data;
        deq_pkg::cell_op_t     op;

        if (g == 0)
        begin : g_head
            assign l_valid = 1'b1;
            assign l_data  = value_w;
        end
        else
        begin : g_mid
            assign l_valid = cell_valid[g-1];
            assign l_data  = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_data  = '0;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[g+1];
            assign r_data  = cell_data[g+1];
        end

        // Only cell 0 takes a front overwrite; nothing moves without a transfer
        always_comb
        begin
            if (!accept)
            begin
                op = deq_pkg::CO_HOLD;
            end
            else if (row_op == deq_pkg::CO_WRITE_HEAD && g != 0)
            begin
                op = deq_pkg::CO_HOLD;
            end
            else
            begin
                op = row_op;
            end
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .value       (value_w),
            .left_valid  (l_valid),
            .left_data   (l_data),
            .right_valid (r_valid),
            .right_data  (r_data),
            .valid       (cell_valid[g]),
            .data        (cell_data[g]),
            .tail_data   (cell_tail_data[g])
        );
    end

    // Hold the entry count and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result payload on each transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg   <= rd_ext[RdataW-1:0];
            rsp_count_reg  <= CountW'(count_next);
            rsp_status_reg <= status_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_data_reg;
    assign rsp.count  = rsp_count_reg;
    assign rsp.status = rsp_status_reg;

endmodule

// File: sv/deq_cell.sv
// One storage cell of the queue row: an entry and its valid bit.
// Trades data with its left and right neighbours. Depends on deq_pkg.
module deq_cell #(
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_pkg::cell_op_t     op,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic                  left_valid,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  right_valid,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic                  valid,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] tail_data
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  is_tail;
    logic                  is_slot;

    // Locate the back entry and the first free place
    assign is_tail = valid_reg & ~right_valid;
    assign is_slot = ~valid_reg & left_valid;

    // Apply the command
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (op)
            deq_pkg::CO_HOLD:
            begin
            end
            deq_pkg::CO_FROM_LEFT:
            begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            deq_pkg::CO_FROM_RIGHT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            deq_pkg::CO_APPEND:
            begin
                if (is_slot)
                begin
                    valid_next = 1'b1;
                    data_next  = value;
                end
            end
            deq_pkg::CO_DROP_TAIL:
            begin
                if (is_tail)
                begin
                    valid_next = 1'b0;
                end
            end
            deq_pkg::CO_WRITE_TAIL:
            begin
                if (is_tail)
                begin
                    data_next = value;
                end
            end
            deq_pkg::CO_WRITE_HEAD:
            begin
                data_next = value;
            end
            deq_pkg::CO_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // Hold the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid     = valid_reg;
    assign data      = data_reg;
    assign tail_data = data_reg & {DATA_WIDTH{is_tail}};

endmodule
